### rtl/core/frustum_mesh_generator_macros.svh
// assertion macros shared by the frustum mesh generator modules
`ifndef FRUSTUM_MESH_GENERATOR_MACROS_SVH
`define FRUSTUM_MESH_GENERATOR_MACROS_SVH

// property checked on every rising edge outside reset
`define FMG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define FMG_NEVER(lbl, cond, msg) \
  `FMG_ASSERT(lbl, !(cond), msg)

`endif

### rtl/core/fmg_pkg.sv
// shared types, constants and helpers of the frustum mesh generator
`timescale 1ns / 1ps
package fmg_pkg;

  localparam int SEG_W       = 11;
  localparam int MAX_SEG     = 1024;
  localparam int IDX_W       = 12;
  localparam int RING_W      = 10;
  localparam int LEN_W       = 16;
  localparam int TRIG_BITS   = 16;
  localparam int QUO_W       = TRIG_BITS + 1;
  localparam int REM_W       = SEG_W + 1;
  localparam int FRAC_W      = TRIG_BITS - 2;
  localparam int TERMS       = 7;
  localparam int TRIG_LAT    = 1 + QUO_W + 2 + 3 * TERMS + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 168;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_HEIGHT   = 2'd0,
    REG_TOP_DIAM = 2'd1,
    REG_BOT_DIAM = 2'd2,
    REG_SEGMENTS = 2'd3
  } cfg_reg_t;

  // classified request, as it travels from front to back
  typedef struct packed {
    logic              triangle;
    logic              bad;
    logic              centre;
    logic              top;
    logic [RING_W-1:0] ring_i;
    logic [IDX_W-1:0]  ca;
    logic [IDX_W-1:0]  cb;
    logic [IDX_W-1:0]  cc;
  } item_t;

  // segment count as used: zero taken as one, capped at the maximum
  function automatic logic [SEG_W-1:0] eff_segments(input logic [SEG_W-1:0] s);
    logic [SEG_W-1:0] r;
    r = s;
    if (s == '0) r = SEG_W'(1);
    else if (s > SEG_W'(MAX_SEG)) r = SEG_W'(MAX_SEG);
    return r;
  endfunction

  // taylor divisors of term k
  function automatic int cos_div(input int k);
    return (2 * k - 1) * (2 * k);
  endfunction

  function automatic int sin_div(input int k);
    return (2 * k) * (2 * k + 1);
  endfunction

endpackage

### rtl/core/fmg_front.sv
// front end: classifies a request and works out triangle corners
`timescale 1ns / 1ps
module fmg_front (
  input  logic                     mode_i,
  input  logic [fmg_pkg::IDX_W-1:0] index_i,
  input  logic [fmg_pkg::SEG_W-1:0] seg_i,
  output fmg_pkg::item_t            item_o
);

  logic [fmg_pkg::IDX_W:0] k, r, two_r, three_r, four_r, i_sel, n_sel;

  // decode vertex or triangle index against the ring size
  always_comb begin
    k       = {1'b0, index_i};
    r       = (fmg_pkg::IDX_W + 1)'(seg_i);
    two_r   = r << 1;
    three_r = two_r + r;
    four_r  = r << 2;
    i_sel   = '0;
    n_sel   = '0;
    item_o  = '0;
    item_o.triangle = mode_i;
    if (!mode_i) begin
      if (k >= two_r + 13'd2) begin
        item_o.bad = 1'b1;
      end else begin
        item_o.centre = (k >= two_r);
        item_o.top    = (k >= two_r) ? (k == two_r) : (k < r);
        item_o.ring_i = fmg_pkg::RING_W'((k < r) ? k : k - r);
      end
    end else if (k >= four_r) begin
      item_o.bad = 1'b1;
    end else begin
      if (k < two_r) i_sel = k >> 1;
      else if (k < three_r) i_sel = k - two_r;
      else i_sel = k - three_r;
      n_sel = (i_sel + 13'd1 == r) ? '0 : i_sel + 13'd1;
      if (k < two_r) begin
        if (!k[0]) begin
          item_o.ca = fmg_pkg::IDX_W'(i_sel);
          item_o.cb = fmg_pkg::IDX_W'(i_sel + r);
          item_o.cc = fmg_pkg::IDX_W'(n_sel);
        end else begin
          item_o.ca = fmg_pkg::IDX_W'(n_sel);
          item_o.cb = fmg_pkg::IDX_W'(i_sel + r);
          item_o.cc = fmg_pkg::IDX_W'(n_sel + r);
        end
      end else if (k < three_r) begin
        item_o.ca = fmg_pkg::IDX_W'(two_r);
        item_o.cb = fmg_pkg::IDX_W'(i_sel);
        item_o.cc = fmg_pkg::IDX_W'(n_sel);
      end else begin
        item_o.ca = fmg_pkg::IDX_W'(two_r + 13'd1);
        item_o.cb = fmg_pkg::IDX_W'(n_sel + r);
        item_o.cc = fmg_pkg::IDX_W'(i_sel + r);
      end
    end
  end

endmodule

### rtl/core/fmg_queue.sv
// short queue between the front end and the vertex pipeline
`timescale 1ns / 1ps
`include "frustum_mesh_generator_macros.svh"
module fmg_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  fmg_pkg::item_t item_i,
  input  logic           pop_i,
  output fmg_pkg::item_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  fmg_pkg::item_t               mem_r [fmg_pkg::QUEUE_DEPTH];
  logic [fmg_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [fmg_pkg::QPTR_W:0]     count_r, count_nxt;

  assign full_o  = (count_r == (fmg_pkg::QPTR_W + 1)'(fmg_pkg::QUEUE_DEPTH));
  assign empty_o = (count_r == '0);
  assign head_o  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push_i && !pop_i) count_nxt = count_r + 1'b1;
    else if (!push_i && pop_i) count_nxt = count_r - 1'b1;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_i) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= item_i;
  end

  `FMG_NEVER(a_q_overfill, count_r > (fmg_pkg::QPTR_W + 1)'(fmg_pkg::QUEUE_DEPTH), "queue overfilled")
  `FMG_NEVER(a_q_pop_empty, pop_i && empty_o, "pop from empty queue")
  `FMG_ASSERT(a_q_count_up, push_i && !pop_i |=> count_r == $past(count_r) + 1'b1, "count lost a push")

endmodule

### rtl/core/fmg_trig.sv
// phase divider and pipelined taylor sine and cosine in q30
`timescale 1ns / 1ps
module fmg_trig (
  input  logic                      clk,
  input  logic                      en_i,
  input  logic [fmg_pkg::RING_W-1:0] idx_i,
  input  logic [fmg_pkg::SEG_W-1:0]  seg_i,
  output logic signed [31:0]        cos_o,
  output logic signed [31:0]        sin_o
);

  localparam int QW = fmg_pkg::QUO_W;
  localparam int RW = fmg_pkg::REM_W;
  localparam int NT = fmg_pkg::TERMS;

  typedef struct packed {
    logic [31:0]        tc;
    logic [31:0]        ts;
    logic signed [33:0] cv;
    logic signed [33:0] sv;
    logic [31:0]        x2;
    logic [1:0]         quad;
  } rnd_t;

  logic [RW-1:0] rem_r [QW+1];
  logic [QW-1:0] quo_r [QW+1];
  logic [RW-1:0] d2;
  logic [QW-1:0] low;

  logic [30:0]   x_r;
  logic [1:0]    quad_x_r;
  rnd_t          st_r [NT+1];
  rnd_t          sa_r [NT+1];
  rnd_t          sb_r [NT+1];
  logic [63:0]   pc_r [NT+1];
  logic [63:0]   ps_r [NT+1];
  logic [32:0]   vc_r [NT+1];
  logic [32:0]   vs_r [NT+1];
  logic [32:0]   qc_r [NT+1];
  logic [32:0]   qs_r [NT+1];

  assign d2  = {seg_i, 1'b0};
  assign low = QW'(seg_i);

  // divider entry: numerator is idx * 2^(QW) + seg, divisor 2 * seg
  always_ff @(posedge clk) begin
    if (en_i) begin
      rem_r[0] <= RW'(idx_i);
      quo_r[0] <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RW:0] t;
    logic        ge;
    always_comb begin
      t  = {rem_r[j], low[QW-1-j]};
      ge = (t >= {1'b0, d2});
    end
    always_ff @(posedge clk) begin
      if (en_i) begin
        rem_r[j+1] <= ge ? RW'(t - {1'b0, d2}) : t[RW-1:0];
        quo_r[j+1] <= {quo_r[j][QW-2:0], ge};
      end
    end
  end

  // angle within the quadrant, then its square
  logic [fmg_pkg::FRAC_W+30:0] xm;
  logic [61:0]                 xx;
  assign xm = fmg_pkg::FRAC_W'(quo_r[QW][fmg_pkg::FRAC_W-1:0]) * fmg_pkg::HALF_PI_Q30
            + (fmg_pkg::FRAC_W + 31)'(1 << (fmg_pkg::FRAC_W - 1));
  assign xx = x_r * x_r;

  always_ff @(posedge clk) begin
    if (en_i) begin
      x_r      <= xm[fmg_pkg::FRAC_W+30:fmg_pkg::FRAC_W];
      quad_x_r <= quo_r[QW][fmg_pkg::TRIG_BITS-1:fmg_pkg::TRIG_BITS-2];
      st_r[0].tc   <= 32'h4000_0000;
      st_r[0].ts   <= 32'(x_r);
      st_r[0].cv   <= 34'sd1073741824;
      st_r[0].sv   <= $signed({3'b0, x_r});
      st_r[0].x2   <= xx[61:30];
      st_r[0].quad <= quad_x_r;
    end
  end

  // one series term per round: multiply, reciprocal multiply, correct and add
  for (genvar k = 1; k <= NT; k++) begin : g_term
    localparam int          CD  = fmg_pkg::cos_div(k);
    localparam int          SD  = fmg_pkg::sin_div(k);
    localparam logic [7:0]  CDV = 8'(CD);
    localparam logic [7:0]  SDV = 8'(SD);
    localparam logic [33:0] MC  = 34'((64'd1 << 34) / CD);
    localparam logic [33:0] MS  = 34'((64'd1 << 34) / SD);
    localparam bit          ODD = (k % 2) == 1;

    logic [66:0] mc, ms;
    logic [40:0] prc, prs, rc, rs;
    logic [32:0] q_c, q_s;
    rnd_t        nxt;

    always_comb begin
      mc  = pc_r[k][62:30] * MC;
      ms  = ps_r[k][62:30] * MS;
      prc = 41'(qc_r[k]) * 41'(CDV);
      prs = 41'(qs_r[k]) * 41'(SDV);
      rc  = 41'(vc_r[k]) - prc;
      rs  = 41'(vs_r[k]) - prs;
      q_c = qc_r[k] + 33'(rc >= 41'(CDV));
      q_s = qs_r[k] + 33'(rs >= 41'(SDV));
      nxt    = sb_r[k];
      nxt.tc = q_c[31:0];
      nxt.ts = q_s[31:0];
      nxt.cv = ODD ? sb_r[k].cv - $signed({2'b0, q_c[31:0]})
                   : sb_r[k].cv + $signed({2'b0, q_c[31:0]});
      if (k < NT) begin
        nxt.sv = ODD ? sb_r[k].sv - $signed({2'b0, q_s[31:0]})
                     : sb_r[k].sv + $signed({2'b0, q_s[31:0]});
      end
    end

    always_ff @(posedge clk) begin
      if (en_i) begin
        sa_r[k] <= st_r[k-1];
        pc_r[k] <= st_r[k-1].tc * st_r[k-1].x2;
        ps_r[k] <= st_r[k-1].ts * st_r[k-1].x2;
        sb_r[k] <= sa_r[k];
        vc_r[k] <= pc_r[k][62:30];
        vs_r[k] <= ps_r[k][62:30];
        qc_r[k] <= mc[66:34];
        qs_r[k] <= ms[66:34];
        st_r[k] <= nxt;
      end
    end
  end

  function automatic logic [30:0] clamp_q30(input logic signed [33:0] v);
    logic [30:0] r;
    if (v < 0) r = '0;
    else if (v > 34'sd1073741824) r = 31'h4000_0000;
    else r = v[30:0];
    return r;
  endfunction

  logic signed [31:0] cq, sq;
  assign cq = $signed({1'b0, clamp_q30(st_r[NT].cv)});
  assign sq = $signed({1'b0, clamp_q30(st_r[NT].sv)});

  // clamp and unfold the quadrant
  always_ff @(posedge clk) begin
    if (en_i) begin
      case (st_r[NT].quad)
        2'd0:    begin cos_o <= cq;  sin_o <= sq;  end
        2'd1:    begin cos_o <= -sq; sin_o <= cq;  end
        2'd2:    begin cos_o <= -cq; sin_o <= -sq; end
        default: begin cos_o <= sq;  sin_o <= -cq; end
      endcase
    end
  end

endmodule

### rtl/core/fmg_back.sv
// back end: vertex pipeline, result formatting and output register
`timescale 1ns / 1ps
`include "frustum_mesh_generator_macros.svh"
module fmg_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [fmg_pkg::LEN_W-1:0]        height_i,
  input  logic [fmg_pkg::LEN_W-1:0]        top_diam_i,
  input  logic [fmg_pkg::LEN_W-1:0]        bot_diam_i,
  input  logic [fmg_pkg::SEG_W-1:0]        seg_i,
  input  fmg_pkg::item_t                   head_i,
  input  logic                             head_valid_i,
  output logic                             pop_o,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fmg_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tuser
);

  localparam int L = fmg_pkg::TRIG_LAT;

  fmg_pkg::item_t                  ctx_r [L];
  logic                            vld_r [L];
  logic                            en;
  logic signed [31:0]              cos_w, sin_w;
  logic                            out_valid_r;
  logic [fmg_pkg::OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic                            out_bad_r;

  // the whole pipeline stalls only when the output register is held
  assign en    = !out_valid_r || out_tready;
  assign pop_o = en && head_valid_i;

  fmg_trig u_trig (
    .clk   (clk),
    .en_i  (en),
    .idx_i (head_i.ring_i),
    .seg_i (seg_i),
    .cos_o (cos_w),
    .sin_o (sin_w)
  );

  // context rides alongside the trig pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < L; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= head_valid_i;
      for (int s = 1; s < L; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= head_i;
      for (int s = 1; s < L; s++) ctx_r[s] <= ctx_r[s-1];
    end
  end

  function automatic logic [15:0] ring_coord(input logic [15:0] d,
                                             input logic signed [31:0] v);
    logic [30:0] m;
    logic [46:0] p;
    logic [16:0] r;
    logic [15:0] o;
    m = (v < 0) ? 31'(-v) : v[30:0];
    p = d * m + (47'd1 << 30);
    r = {1'b0, p[46:31]};
    if (v < 0) o = 16'(-r);
    else o = (r > 17'd32767) ? 16'h7fff : r[15:0];
    return o;
  endfunction

  function automatic logic [15:0] to_q14(input logic signed [31:0] v);
    logic [30:0] m;
    logic [31:0] t;
    logic [15:0] r;
    m = (v < 0) ? 31'(-v) : v[30:0];
    t = {1'b0, m} + 32'd32768;
    r = t[31:16];
    return (v < 0) ? -r : r;
  endfunction

  function automatic logic [14:0] to_uv(input logic signed [31:0] v);
    logic signed [33:0] t;
    t = 34'sd1073741824 + 34'(v) + 34'sd65536;
    return t[31:17];
  endfunction

  fmg_pkg::item_t     last;
  logic [16:0]        half_h;
  logic [15:0]        top_y, pos_y, diam;
  logic [15:0]        px, pz, nx, ny, nz;
  logic [14:0]        tu, tv;
  logic [11:0]        ca, cb, cc;

  // result fields from the last pipeline stage
  always_comb begin
    last   = ctx_r[L-1];
    half_h = (17'(height_i) + 17'd1) >> 1;
    top_y  = (half_h > 17'd32767) ? 16'h7fff : half_h[15:0];
    pos_y  = last.top ? top_y : 16'(-half_h);
    diam   = last.top ? top_diam_i : bot_diam_i;
    px = '0; pz = '0; nx = '0; ny = '0; nz = '0;
    tu = '0; tv = '0; ca = '0; cb = '0; cc = '0;
    if (!last.bad) begin
      if (last.triangle) begin
        ca = last.ca;
        cb = last.cb;
        cc = last.cc;
      end else if (last.centre) begin
        tu = 15'd8192;
        tv = 15'd8192;
        ny = last.top ? 16'sd16384 : -16'sd16384;
      end else begin
        px = ring_coord(diam, cos_w);
        pz = ring_coord(diam, sin_w);
        tu = to_uv(cos_w);
        tv = to_uv(sin_w);
        nx = to_q14(cos_w);
        nz = to_q14(sin_w);
      end
    end
    out_data_nxt = {6'b0, cc, cb, ca, nz, ny, nx, tv, tu, pz,
                    (last.bad || last.triangle) ? 16'h0000 : pos_y, px};
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_bad_r  <= last.bad;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_bad_r;

  `FMG_ASSERT(a_b_hold, out_valid_r && !out_tready |=> $stable(vld_r[L-1]), "pipeline moved in stall")
  `FMG_ASSERT(a_b_bad_zero, out_valid_r && out_bad_r |-> out_data_r == '0, "bad beat carries data")
  `FMG_ASSERT(a_b_tri_clean, out_valid_r && (|out_data_r[161:126]) |-> out_data_r[125:0] == '0, "triangle beat carries vertex data")

endmodule

### rtl/core/frustum_mesh_generator.sv
// top level of the frustum mesh generator
//
// Each input beat asks for one vertex (tuser 0) or one triangle (tuser 1) of a
// truncated cone by index and yields exactly one output beat, in order. One
// beat is taken per cycle sustained while the output is not stalled. A request
// passes through the queue, then the 17-step pipelined phase divider, the
// angle and its square, the seven-term sine and cosine series at three
// stages per term, the quadrant unfold and the output register. A four-beat
// queue between the request decoder and the pipeline lets either side stall
// on its own. Configuration must be written only while no request is in
// flight.
`timescale 1ns / 1ps
module frustum_mesh_generator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // element_index [11:0], zero pad [15:12]
  input  logic         in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, normal_x, normal_y, normal_z,
  // corner_a, corner_b, corner_c, zero pad
  output logic [167:0] out_tdata,
  output logic         out_tuser,  // bad_index
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [fmg_pkg::LEN_W-1:0] height_r, top_diam_r, bot_diam_r;
  logic [fmg_pkg::SEG_W-1:0] seg_r, seg_eff;
  fmg_pkg::item_t            front_item, head;
  logic                      q_full, q_empty, pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r   <= 16'd256;
      top_diam_r <= 16'd256;
      bot_diam_r <= 16'd256;
      seg_r      <= 11'd32;
    end else if (cfg_we) begin
      unique case (fmg_pkg::cfg_reg_t'(cfg_index))
        fmg_pkg::REG_HEIGHT:   height_r   <= cfg_data;
        fmg_pkg::REG_TOP_DIAM: top_diam_r <= cfg_data;
        fmg_pkg::REG_BOT_DIAM: bot_diam_r <= cfg_data;
        fmg_pkg::REG_SEGMENTS: seg_r      <= cfg_data[fmg_pkg::SEG_W-1:0];
        default: ;
      endcase
    end
  end

  assign seg_eff   = fmg_pkg::eff_segments(seg_r);
  assign in_tready = !q_full;

  fmg_front u_front (
    .mode_i  (in_tuser),
    .index_i (in_tdata[fmg_pkg::IDX_W-1:0]),
    .seg_i   (seg_eff),
    .item_o  (front_item)
  );

  fmg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (in_tvalid && in_tready),
    .item_i  (front_item),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  fmg_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .height_i     (height_r),
    .top_diam_i   (top_diam_r),
    .bot_diam_i   (bot_diam_r),
    .seg_i        (seg_eff),
    .head_i       (head),
    .head_valid_i (!q_empty),
    .pop_o        (pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser)
  );

endmodule

### sim/frustum_mesh_generator_checker.sv
// mesh element predictor and result scoreboard for the frustum mesh generator
`timescale 1ns / 1ps
module frustum_mesh_generator_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [15:0]  in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [167:0] out_tdata,
  input  logic         out_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output int           pending,
  output int           errors
);

  typedef struct {
    logic signed [15:0] pos_x, pos_y, pos_z;
    logic [14:0]        tex_u, tex_v;
    logic signed [15:0] nrm_x, nrm_y, nrm_z;
    logic [11:0]        corner_a, corner_b, corner_c;
    logic               bad_index;
  } mesh_elem_t;

  mesh_elem_t elem_q[$];

  // shadow of the configuration registers
  logic [15:0] height_r, top_diam_r, bot_diam_r;
  logic [10:0] seg_r;

  // cos and sin of 2*pi*i/r in Q30 via quantized phase and taylor series
  function automatic void angle_trig(input longint unsigned i, input longint unsigned r,
                                     output longint c, output longint s);
    longint unsigned phase, quad, rm, x, x2, ts, tc;
    longint sv, cv;
    phase = ((i << 17) + r) / (2 * r);
    phase = phase & 64'hFFFF;
    quad  = phase >> 14;
    rm    = phase & 64'h3FFF;
    x     = (rm * longint'(fmg_pkg::HALF_PI_Q30) + 64'd8192) >> 14;
    x2    = (x * x) >> 30;
    sv    = longint'(x);
    cv    = 64'sd1 << 30;
    ts    = x;
    tc    = 64'd1 << 30;
    for (int k = 1; k <= 7; k++) begin
      tc = ((tc * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
      if (k & 1) cv -= longint'(tc); else cv += longint'(tc);
      if (k <= 6) begin
        ts = ((ts * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k & 1) sv -= longint'(ts); else sv += longint'(ts);
      end
    end
    if (sv < 0) sv = 0;
    if (sv > (64'sd1 << 30)) sv = 64'sd1 << 30;
    if (cv < 0) cv = 0;
    if (cv > (64'sd1 << 30)) cv = 64'sd1 << 30;
    case (quad)
      0: begin c = cv;  s = sv;  end
      1: begin c = -sv; s = cv;  end
      2: begin c = -cv; s = -sv; end
      default: begin c = sv; s = -cv; end
    endcase
  endfunction

  // Q30 to Q2.14, rounded half away from zero
  function automatic longint to_q14(input longint v);
    longint m, r;
    m = v < 0 ? -v : v;
    r = (m + 32768) >>> 16;
    return v < 0 ? -r : r;
  endfunction

  // diameter * trig / 2 in Q8.8, saturated on the positive side
  function automatic longint ring_pos(input longint d, input longint v);
    longint m, r;
    m = v < 0 ? -v : v;
    r = (d * m + (64'sd1 << 30)) >>> 31;
    if (v < 0) return -r;
    return r > 32767 ? 32767 : r;
  endfunction

  // expected result of one request
  function automatic mesh_elem_t mesh_element(input logic tri_mode, input logic [11:0] idx);
    mesh_elem_t e;
    longint unsigned r, k, i, n, a, b, cc;
    longint half_h, top_y, c, s, d;
    logic top;
    e = '{default: '0};
    r = seg_r;
    if (r == 0) r = 1;
    if (r > fmg_pkg::MAX_SEG) r = fmg_pkg::MAX_SEG;
    k = idx;
    half_h = (longint'(height_r) + 1) >>> 1;
    top_y = half_h > 32767 ? 32767 : half_h;
    if (!tri_mode) begin
      if (k >= 2 * r + 2) begin
        e.bad_index = 1'b1;
      end else if (k >= 2 * r) begin
        top = (k == 2 * r);
        e.pos_y = top ? 16'(top_y) : 16'(-half_h);
        e.tex_u = 15'd8192;
        e.tex_v = 15'd8192;
        e.nrm_y = top ? 16'sd16384 : -16'sd16384;
      end else begin
        top = k < r;
        i = top ? k : k - r;
        d = top ? top_diam_r : bot_diam_r;
        angle_trig(i, r, c, s);
        e.pos_x = 16'(ring_pos(d, c));
        e.pos_y = top ? 16'(top_y) : 16'(-half_h);
        e.pos_z = 16'(ring_pos(d, s));
        e.tex_u = 15'(((64'sd1 << 30) + c + 65536) >>> 17);
        e.tex_v = 15'(((64'sd1 << 30) + s + 65536) >>> 17);
        e.nrm_x = 16'(to_q14(c));
        e.nrm_z = 16'(to_q14(s));
      end
    end else if (k >= 4 * r) begin
      e.bad_index = 1'b1;
    end else begin
      if (k < 2 * r) begin
        i = k >> 1;
        n = (i + 1) % r;
        if (k[0] == 1'b0) begin a = i; b = i + r; cc = n; end
        else begin a = n; b = i + r; cc = n + r; end
      end else if (k < 3 * r) begin
        i = k - 2 * r;
        n = (i + 1) % r;
        a = 2 * r; b = i; cc = n;
      end else begin
        i = k - 3 * r;
        n = (i + 1) % r;
        a = 2 * r + 1; b = n + r; cc = i + r;
      end
      e.corner_a = 12'(a);
      e.corner_b = 12'(b);
      e.corner_c = 12'(cc);
    end
    return e;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  assign pending = elem_q.size();

  // register writes, request capture and result compare
  always @(posedge clk) begin
    mesh_elem_t w;
    if (!rst_n) begin
      height_r   <= 16'd256;
      top_diam_r <= 16'd256;
      bot_diam_r <= 16'd256;
      seg_r      <= 11'd32;
      errors     = 0;
      elem_q.delete();
    end else begin
      if (cfg_we) begin
        case (fmg_pkg::cfg_reg_t'(cfg_index))
          fmg_pkg::REG_HEIGHT:   height_r   <= cfg_data;
          fmg_pkg::REG_TOP_DIAM: top_diam_r <= cfg_data;
          fmg_pkg::REG_BOT_DIAM: bot_diam_r <= cfg_data;
          fmg_pkg::REG_SEGMENTS: seg_r      <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        elem_q.insert(elem_q.size(), mesh_element(in_tuser, in_tdata[11:0]));
      if (out_tvalid && out_tready) begin
        if (elem_q.size() == 0) begin
          $error("result beat with no request outstanding");
          errors++;
        end else begin
          w = elem_q.pop_front();
          check_field("pos_x", w.pos_x, $signed(out_tdata[15:0]));
          check_field("pos_y", w.pos_y, $signed(out_tdata[31:16]));
          check_field("pos_z", w.pos_z, $signed(out_tdata[47:32]));
          check_field("tex_u", w.tex_u, out_tdata[62:48]);
          check_field("tex_v", w.tex_v, out_tdata[77:63]);
          check_field("normal_x", w.nrm_x, $signed(out_tdata[93:78]));
          check_field("normal_y", w.nrm_y, $signed(out_tdata[109:94]));
          check_field("normal_z", w.nrm_z, $signed(out_tdata[125:110]));
          check_field("corner_a", w.corner_a, out_tdata[137:126]);
          check_field("corner_b", w.corner_b, out_tdata[149:138]);
          check_field("corner_c", w.corner_c, out_tdata[161:150]);
          check_field("bad_index", w.bad_index, out_tuser);
        end
      end
    end
  end

endmodule

### sim/frustum_mesh_generator_tb.sv
// stimulus and verdict for the frustum mesh generator
`timescale 1ns / 1ps
module frustum_mesh_generator_tb;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [15:0]  in_tdata;    // element_index [11:0], zero pad [15:12]
  logic         in_tuser;    // mode
  logic         out_tvalid;
  logic         out_tready;
  logic [167:0] out_tdata;   // pos_x .. corner_c, zero pad
  logic         out_tuser;   // bad_index
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_data;
  int           pending;
  int           errors;
  logic         in_fire, out_fire;
  int           seg_eff;
  int           sent_beats, recv_beats;

  frustum_mesh_generator dut (.*);

  frustum_mesh_generator_checker u_checker (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // handshakes seen at the edge, read back at the following falling edge
  always @(posedge clk) begin
    in_fire  <= in_tvalid && in_tready;
    out_fire <= out_tvalid && out_tready;
  end

  // run limit
  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin
    int gap;
    out_tready = 1'b0;
    recv_beats = 0;
    wait (rst_n);
    forever begin
      gap = ((recv_beats / 48) % 3 == 2) ? 0 : $urandom_range(0, 8);
      if (recv_beats == 400) gap = 300;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(negedge clk); while (!out_fire);
      recv_beats++;
    end
  end

  task automatic cfg_write(input fmg_pkg::cfg_reg_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // offer one request beat and hold it until taken
  task automatic send_req(input logic tri_mode, input int idx);
    int gap;
    gap = ((sent_beats / 40) % 3 == 1) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= tri_mode;
    in_tdata  <= {4'd0, 12'(idx)};
    do @(negedge clk); while (!in_fire);
    sent_beats++;
  endtask

  // let every result drain and the pipeline settle, then write all four settings
  task automatic set_shape(input logic [15:0] h, input logic [15:0] td,
                           input logic [15:0] bd, input logic [15:0] seg);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_write(fmg_pkg::REG_HEIGHT, h);
    cfg_write(fmg_pkg::REG_TOP_DIAM, td);
    cfg_write(fmg_pkg::REG_BOT_DIAM, bd);
    cfg_write(fmg_pkg::REG_SEGMENTS, seg);
    cfg_we <= 1'b0;
    seg_eff = seg[10:0];
    if (seg_eff == 0) seg_eff = 1;
    if (seg_eff > fmg_pkg::MAX_SEG) seg_eff = fmg_pkg::MAX_SEG;
  endtask

  // random requests, mostly inside the mesh with edges just past it
  task automatic random_reqs(input int n);
    logic m;
    int lim;
    repeat (n) begin
      m = 1'($urandom_range(0, 1));
      lim = m ? 4 * seg_eff : 2 * seg_eff + 2;
      if (lim > 4095) lim = 4095;
      if ($urandom_range(0, 9) < 8) send_req(m, $urandom_range(0, lim));
      else send_req(m, $urandom_range(0, 4095));
    end
  endtask

  // stimulus
  initial begin
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = fmg_pkg::REG_HEIGHT;
    cfg_data  = '0;
    rst_n     = 1'b0;
    seg_eff   = 32;
    sent_beats = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: ring ends, centres, one past the mesh, all-ones index
    send_req(1'b0, 0);
    send_req(1'b0, 8);
    send_req(1'b0, 31);
    send_req(1'b0, 32);
    send_req(1'b0, 63);
    send_req(1'b0, 64);
    send_req(1'b0, 65);
    send_req(1'b0, 66);
    send_req(1'b0, 4095);
    send_req(1'b1, 0);
    send_req(1'b1, 1);
    send_req(1'b1, 63);
    send_req(1'b1, 64);
    send_req(1'b1, 95);
    send_req(1'b1, 96);
    send_req(1'b1, 127);
    send_req(1'b1, 128);
    send_req(1'b1, 4095);
    random_reqs(120);

    // zero sizes with a zero segment count, then full-scale sizes at the cap
    set_shape(16'd0, 16'd0, 16'd0, 16'h0800);
    random_reqs(100);
    set_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_reqs(250);
    set_shape(16'h1234, 16'hFFFF, 16'd1, 16'd3);
    random_reqs(150);
    set_shape(16'hFFFE, 16'hABCD, 16'h5432, 16'd1024);
    random_reqs(120);
    set_shape(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'd7);
    random_reqs(150);
    set_shape(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'd1);
    random_reqs(140);

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/fmg_pkg.sv
rtl/core/fmg_front.sv
rtl/core/fmg_queue.sv
rtl/core/fmg_trig.sv
rtl/core/fmg_back.sv
rtl/core/frustum_mesh_generator.sv
sim/frustum_mesh_generator_checker.sv
sim/frustum_mesh_generator_tb.sv
